>>> design/hpfc_pkg.sv
// shared types and constants for the host pair flow counter
// no dependencies; compiled before every other file of the block
package hpfc_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
    localparam logic [10:0] ETH_HDR_BYTES = 11'd14;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;

    localparam logic       KIND_PACKET = 1'b0;
    localparam logic       KIND_READ   = 1'b1;

    localparam logic [2:0] ST_UPDATED    = 3'd0;
    localparam logic [2:0] ST_INSERTED   = 3'd1;
    localparam logic [2:0] ST_IGNORED    = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL = 3'd3;
    localparam logic [2:0] ST_READ_OK    = 3'd4;
    localparam logic [2:0] ST_READ_EMPTY = 3'd5;

    typedef struct packed {
        logic        kind;
        logic [15:0] frame_type;
        logic [10:0] capture_len;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] ip_total_len;
        logic [3:0]  ip_hdr_words;
        logic [3:0]  tcp_hdr_words;
        logic [5:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  entry_index;
        logic [31:0] pair_source;
        logic [31:0] pair_dest;
        logic [31:0] packet_count;
        logic [39:0] byte_volume;
        logic [6:0]  entries_used;
    } out_item_t;

    // one table entry as it sits in the memory
    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] count;
        logic [39:0] volume;
    } entry_t;

    // packet classification handed to the engine
    typedef struct packed {
        logic        counted;
        logic [15:0] payload;
    } pkt_info_t;

endpackage

>>> design/hpfc_in_if.sv
// input channel: valid/ready handshake carrying one packet or read request
// depends on hpfc_pkg
interface hpfc_in_if import hpfc_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/hpfc_out_if.sv
// result channel: valid/ready handshake carrying one result item
// depends on hpfc_pkg
interface hpfc_out_if import hpfc_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/hpfc_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module hpfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/hpfc_classify.sv
// packet filter: decides whether a header is counted and works out its tcp payload
// depends on hpfc_pkg
module hpfc_classify import hpfc_pkg::*; (
    input  in_item_t  item,
    output pkt_info_t info
);

    logic [6:0]  hdr_bytes;
    logic [15:0] hdr_ext;

    assign hdr_bytes = 7'({item.ip_hdr_words, 2'b00}) + 7'({item.tcp_hdr_words, 2'b00});
    assign hdr_ext   = 16'(hdr_bytes);

    assign info.counted = (item.frame_type == ETYPE_IPV4)
                       && (item.capture_len > ETH_HDR_BYTES)
                       && (item.ip_protocol == PROTO_TCP)
                       && (item.tcp_hdr_words != 4'd0);

    // negative payload clamps to zero
    assign info.payload = (item.ip_total_len > hdr_ext) ? (item.ip_total_len - hdr_ext) : 16'd0;

endmodule

>>> design/hpfc_engine.sv
// table engine: scans the entry memory, updates or appends pairs, serves reads
// depends on hpfc_pkg; drives one hpfc_ram instance in the top level
module hpfc_engine import hpfc_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW = $clog2(TABLE_DEPTH + 1),
    localparam int RW = (CW > 6) ? CW : 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  in_item_t      in_item,
    input  pkt_info_t     info,
    output logic          ram_re,
    output logic [AW-1:0] ram_raddr,
    input  entry_t        ram_rdata,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output entry_t        ram_wdata,
    output logic          out_valid,
    input  logic          out_ready,
    output out_item_t     out_item
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_RDWAIT = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_reg, out_next;
    out_item_t     pend_reg, pend_next;
    logic [31:0]   src_reg, src_next;
    logic [31:0]   dst_reg, dst_next;
    logic [15:0]   pay_reg, pay_next;

    logic          ridx_ok;
    logic          hit;
    logic          out_free;
    logic [31:0]   upd_cnt;
    logic [40:0]   upd_sum;
    logic [39:0]   upd_vol;

    assign ridx_ok = (RW'(in_item.read_index) < RW'(used_reg))
                  && (32'(in_item.read_index) < TABLE_DEPTH);
    assign hit     = cmp_valid_reg && (ram_rdata.src == src_reg) && (ram_rdata.dst == dst_reg);
    assign upd_cnt = (&ram_rdata.count) ? ram_rdata.count : ram_rdata.count + 32'd1;
    assign upd_sum = {1'b0, ram_rdata.volume} + 41'(pay_reg);
    assign upd_vol = upd_sum[40] ? {40{1'b1}} : upd_sum[39:0];
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        idx_next       = idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        pend_next      = pend_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        pay_next       = pay_reg;
        in_ready       = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg[AW-1:0];
        ram_we         = 1'b0;
        ram_waddr      = cmp_idx_reg;
        ram_wdata      = '{src: src_reg, dst: dst_reg, count: upd_cnt, volume: upd_vol};

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    pend_next = '0;
                    if (in_item.kind == KIND_READ)
                    begin
                        pend_next.entry_index = in_item.read_index;
                        if (ridx_ok)
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(in_item.read_index);
                            state_next = S_RDWAIT;
                        end
                        else
                        begin
                            pend_next.status = ST_READ_EMPTY;
                            state_next       = S_DONE;
                        end
                    end
                    else if (!info.counted)
                    begin
                        pend_next.status = ST_IGNORED;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        src_next       = in_item.source_address;
                        dst_next       = in_item.dest_address;
                        pay_next       = info.payload;
                        idx_next       = '0;
                        cmp_valid_next = 1'b0;
                        state_next     = S_SEARCH;
                    end
                end
            end

            S_RDWAIT:
            begin
                pend_next.status       = ST_READ_OK;
                pend_next.pair_source  = ram_rdata.src;
                pend_next.pair_dest    = ram_rdata.dst;
                pend_next.packet_count = ram_rdata.count;
                pend_next.byte_volume  = ram_rdata.volume;
                state_next             = S_DONE;
            end

            S_SEARCH:
            begin
                // read of entry idx overlaps the compare of the previously fetched entry
                if (hit)
                begin
                    ram_we                 = 1'b1;
                    pend_next.status       = ST_UPDATED;
                    pend_next.entry_index  = 6'(cmp_idx_reg);
                    pend_next.pair_source  = src_reg;
                    pend_next.pair_dest    = dst_reg;
                    pend_next.packet_count = upd_cnt;
                    pend_next.byte_volume  = upd_vol;
                    state_next             = S_DONE;
                end
                else if (idx_reg < used_reg)
                begin
                    ram_re         = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg[AW-1:0];
                    idx_next       = idx_reg + CW'(1);
                end
                else if (used_reg == CW'(TABLE_DEPTH))
                begin
                    pend_next.status      = ST_TABLE_FULL;
                    pend_next.pair_source = src_reg;
                    pend_next.pair_dest   = dst_reg;
                    state_next            = S_DONE;
                end
                else
                begin
                    ram_we                 = 1'b1;
                    ram_waddr              = AW'(used_reg);
                    ram_wdata              = '{src: src_reg, dst: dst_reg, count: 32'd1,
                                               volume: 40'(pay_reg)};
                    used_next              = used_reg + CW'(1);
                    pend_next.status       = ST_INSERTED;
                    pend_next.entry_index  = 6'(used_reg);
                    pend_next.pair_source  = src_reg;
                    pend_next.pair_dest    = dst_reg;
                    pend_next.packet_count = 32'd1;
                    pend_next.byte_volume  = 40'(pay_reg);
                    state_next             = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_next              = pend_reg;
                    out_next.entries_used = 7'(used_reg);
                    out_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        out_reg     <= out_next;
        pend_reg    <= pend_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        pay_reg     <= pay_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    a_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_SEARCH))
        else $error("table write outside the search phase");

    a_used_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |-> ($past(ram_we) && (used_reg == $past(used_reg) + CW'(1))))
        else $error("entry count moved without an append");

    a_cmp_below_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH && cmp_valid_reg) |-> (CW'(cmp_idx_reg) < used_reg))
        else $error("compare of an entry beyond the filled part of the table");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished transaction did not reach the output register");

endmodule

>>> design/host_pair_flow_counter.sv
// Flow statistics table for IPv4 source/destination pairs. Packet headers that are
// IPv4, longer than the Ethernet header, TCP and with a nonzero data offset bump the
// packet count and TCP payload byte total of their pair; a new pair is appended, and
// with a full table the packet is reported and dropped. Items are handled one at a
// time. A counted packet holds the block while the search walks the entry memory
// through its single read port one entry per cycle. The result is loaded into the
// output register as the block returns to idle and can accept the next item. The
// next item is accepted while a result still waits in the output register. The table
// needs no clearing pass: reset clears the fill count and control state, not the
// entry memory.
// depends on hpfc_pkg, hpfc_in_if, hpfc_out_if, hpfc_ram, hpfc_classify, hpfc_engine
module host_pair_flow_counter import hpfc_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    hpfc_in_if.sink    pkt,
    hpfc_out_if.source res
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    pkt_info_t     info;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    entry_t        ram_rdata;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;

    hpfc_classify u_classify (
        .item (pkt.data),
        .info (info)
    );

    hpfc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hpfc_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pkt.valid),
        .in_ready  (pkt.ready),
        .in_item   (pkt.data),
        .info      (info),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_item  (res.data)
    );

endmodule
